// File: design/emawu_pkg.sv
// Package for the EMA-with-warmup unit: widths, constants, state encoding and
// the command/status structs shared by controller and datapath.
// No dependencies.
package emawu_pkg;

   localparam int DATA_W        = 32;
   localparam int PERIOD_W      = 11;
   localparam int COUNT_W       = 11;
   localparam int SUM_W         = 42;
   localparam int ALPHA_W       = 17;
   localparam int PROD_W        = 50;
   localparam int FRAC_W        = 16;
   localparam int MAX_PERIOD    = 1024;
   localparam int RESET_PERIOD  = 10;
   localparam int ALPHA_NUM     = 131072;
   localparam int RESET_ALPHA   = ALPHA_NUM / (RESET_PERIOD + 1);
   localparam int BITS_PER_STEP = 2;
   localparam int DIV_STEPS     = SUM_W / BITS_PER_STEP;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_ALPHA,
      ST_STEP,
      ST_MODE,
      ST_MEAN,
      ST_EMA,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_alpha;
      logic div_mean;
      logic alpha_load;
      logic res_null;
      logic step;
      logic mul;
      logic ema;
      logic mean;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic alpha_stale;
      logic is_null;
      logic past_period;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// File: design/emawu_div.sv
// Iterative unsigned divider, two quotient bits per cycle, registered result.
// Shared by the alpha derivation and the warm-up mean. Uses emawu_pkg.
module emawu_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [emawu_pkg::SUM_W-1:0]   dividend,
   input  logic [emawu_pkg::COUNT_W-1:0] divisor,
   output logic [emawu_pkg::SUM_W-1:0]   quotient,
   output logic                          done
);
   import emawu_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]     work_ff, work_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [COUNT_W-1:0]   div_ff, div_in;

   always_comb begin
      logic [COUNT_W:0]   trial;
      logic [COUNT_W:0]   diff;
      logic [COUNT_W-1:0] rem_v;
      logic [SUM_W-1:0]   work_v;
      rem_v  = rem_ff;
      work_v = work_ff;
      for (int i = 0; i < BITS_PER_STEP; i++) begin
         trial  = {rem_v, work_v[SUM_W-1]};
         diff   = trial - {1'b0, div_ff};
         work_v = {work_v[SUM_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_v     = diff[COUNT_W-1:0];
            work_v[0] = 1'b1;
         end else begin
            rem_v = trial[COUNT_W-1:0];
         end
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         work_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         work_in = work_v;
         rem_in  = rem_v;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign quotient = work_ff;
   assign done     = done_ff;

endmodule

// File: design/emawu_dpath.sv
// Datapath: period/alpha registers, group state, EMA multiply, output register.
// Uses emawu_pkg and emawu_div; driven by emawu_ctrl commands.
module emawu_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  emawu_pkg::cmd_type             cmd,
   output emawu_pkg::status_type          status,
   input  logic signed [emawu_pkg::DATA_W-1:0] req_sample,
   input  logic                           req_sample_null,
   input  logic                           req_new_group,
   input  logic                           csr_we,
   input  logic [emawu_pkg::PERIOD_W-1:0] csr_wdata,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [emawu_pkg::DATA_W-1:0] rsp_average,
   output logic                           rsp_result_null
);
   import emawu_pkg::*;

   logic [PERIOD_W-1:0]      period_ff, period_in;
   logic [ALPHA_W-1:0]       alpha_ff, alpha_in;
   logic                     stale_ff, stale_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [DATA_W-1:0] smooth_ff, smooth_in;
   logic signed [DATA_W-1:0] x_ff;
   logic                     null_ff;
   logic                     group_ff;
   logic signed [SUM_W-1:0]  sumx_ff, sumx_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DATA_W-1:0] res_avg_ff, res_avg_in;
   logic                     res_null_ff, res_null_in;
   logic signed [DATA_W-1:0] out_avg_ff;
   logic                     out_null_ff;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [PERIOD_W-1:0]      period_clamped;
   logic [COUNT_W-1:0]       count_limit;
   logic [COUNT_W-1:0]       count_base;
   logic signed [SUM_W-1:0]  sum_base;
   logic [SUM_W-1:0]         sum_mag;
   logic                     div_start;
   logic [SUM_W-1:0]         div_dividend;
   logic [COUNT_W-1:0]       div_divisor;
   logic [SUM_W-1:0]         div_quot;
   logic                     div_done;
   logic [SUM_W-1:0]         mean_wide;
   logic signed [DATA_W-1:0] mean;
   logic signed [DATA_W:0]   delta;
   logic signed [PROD_W:0]   prod_full;
   logic signed [DATA_W-1:0] ema_next;

   always_comb begin
      if (csr_wdata == '0) begin
         period_clamped = PERIOD_W'(1);
      end else if (csr_wdata > PERIOD_W'(MAX_PERIOD)) begin
         period_clamped = PERIOD_W'(MAX_PERIOD);
      end else begin
         period_clamped = csr_wdata;
      end
   end

   assign count_limit = COUNT_W'(period_ff) + 1'b1;
   assign count_base  = group_ff ? '0 : count_ff;
   assign sum_base    = group_ff ? '0 : sum_ff;
   assign sumx_in     = sum_base + SUM_W'(x_ff);
   assign sum_mag     = sumx_ff[SUM_W-1] ? SUM_W'(-sumx_ff) : SUM_W'(sumx_ff);

   assign div_start    = cmd.div_alpha | cmd.div_mean;
   assign div_dividend = cmd.div_alpha ? SUM_W'(ALPHA_NUM) : sum_mag;
   assign div_divisor  = cmd.div_alpha ? count_limit : count_ff;

   emawu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .done     (div_done)
   );

   assign mean_wide = sumx_ff[SUM_W-1] ? (~div_quot + 1'b1) : div_quot;
   assign mean      = mean_wide[DATA_W-1:0];

   assign delta     = {x_ff[DATA_W-1], x_ff} - {smooth_ff[DATA_W-1], smooth_ff};
   assign prod_full = $signed({1'b0, alpha_ff}) * delta;
   assign ema_next  = smooth_ff + prod_ff[FRAC_W+DATA_W-1:FRAC_W];

   always_comb begin
      period_in    = period_ff;
      alpha_in     = alpha_ff;
      stale_in     = stale_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      smooth_in    = smooth_ff;
      res_avg_in   = res_avg_ff;
      res_null_in  = res_null_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (csr_we) begin
         period_in = period_clamped;
         stale_in  = 1'b1;
      end
      if (cmd.alpha_load) begin
         alpha_in = div_quot[ALPHA_W-1:0];
         stale_in = 1'b0;
      end
      if (cmd.step) begin
         count_in = (count_base < count_limit) ? count_base + 1'b1 : count_limit;
         sum_in   = sum_base;
      end
      if (cmd.res_null) begin
         res_avg_in  = '0;
         res_null_in = 1'b1;
      end
      if (cmd.mean) begin
         if (count_ff < COUNT_W'(period_ff)) begin
            sum_in = sumx_ff;
         end else begin
            smooth_in = mean;
         end
         res_avg_in  = mean;
         res_null_in = 1'b0;
      end
      if (cmd.ema) begin
         smooth_in   = ema_next;
         res_avg_in  = ema_next;
         res_null_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_W'(RESET_PERIOD);
         alpha_ff     <= ALPHA_W'(RESET_ALPHA);
         stale_ff     <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         smooth_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         alpha_ff     <= alpha_in;
         stale_ff     <= stale_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         smooth_ff    <= smooth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load) begin
         x_ff     <= req_sample;
         null_ff  <= req_sample_null;
         group_ff <= req_new_group;
      end
      if (cmd.step) begin
         sumx_ff <= sumx_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_full[PROD_W-1:0];
      end
      res_avg_ff  <= res_avg_in;
      res_null_ff <= res_null_in;
      if (cmd.out_load) begin
         out_avg_ff  <= res_avg_ff;
         out_null_ff <= res_null_ff;
      end
   end

   assign status.alpha_stale = stale_ff;
   assign status.is_null     = null_ff;
   assign status.past_period = count_ff > COUNT_W'(period_ff);
   assign status.div_done    = div_done;
   assign status.out_free    = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_average     = out_avg_ff;
   assign rsp_result_null = out_null_ff;

endmodule

// File: design/emawu_ctrl.sv
// Controller state machine: sequences load, alpha refresh, count update,
// mean division or EMA multiply, and the output handoff. Uses emawu_pkg.
module emawu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  emawu_pkg::status_type status,
   output emawu_pkg::cmd_type    cmd
);
   import emawu_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = status.alpha_stale ? ST_ALPHA : ST_STEP;
         end
         ST_ALPHA: begin
            if (status.div_done) state_in = ST_STEP;
         end
         ST_STEP: begin
            state_in = status.is_null ? ST_RESULT : ST_MODE;
         end
         ST_MODE: begin
            state_in = status.past_period ? ST_EMA : ST_MEAN;
         end
         ST_MEAN: begin
            if (status.div_done) state_in = ST_RESULT;
         end
         ST_EMA: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_PREP: begin
            cmd.div_alpha = status.alpha_stale;
         end
         ST_ALPHA: begin
            cmd.alpha_load = status.div_done;
         end
         ST_STEP: begin
            cmd.res_null = status.is_null;
            cmd.step     = ~status.is_null;
         end
         ST_MODE: begin
            cmd.mul      = status.past_period;
            cmd.div_mean = ~status.past_period;
         end
         ST_MEAN: begin
            cmd.mean = status.div_done;
         end
         ST_EMA: begin
            cmd.ema = 1'b1;
         end
         ST_RESULT: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_ALPHA || state_ff == ST_MEAN))
      else $error("divider finished outside a wait state");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && !status.out_free) |=> state_ff == ST_RESULT)
      else $error("result dropped while output busy");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_PREP)
      else $error("item load did not start processing");

   a_single_div_start: assert property (@(posedge clock) disable iff (reset)
      !(cmd.div_alpha && cmd.div_mean))
      else $error("two divider starts at once");

endmodule

// File: design/ema_with_average_warmup_unit.sv
// Streaming EMA with warm-up mean over signed Q16.16 samples.
// Input channel req_* (valid/ready): sample, sample_null, new_group.
// Result channel rsp_* (valid/ready): average, result_null, one per item.
// csr_we/csr_wdata write the period N (0 reads as 1, above 1024 as 1024);
// the new alpha is derived on the next item and delays that item's result.
// A warm-up or seeding item gets its mean from a 2-bit-per-cycle divider
// (21 steps), an EMA item uses one registered 17x33 multiply, and a null
// item uses neither. One item is in work at a time; the next is taken once
// the result has been placed in the output register.
// The output register holds a result while rsp_ready is low; the unit
// still finishes the following item and then waits for the register.
// Reset: period 10, alpha 11915, count, sum and smoothed value zero,
// no result pending.
// Uses emawu_pkg, emawu_ctrl, emawu_dpath.
module ema_with_average_warmup_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [emawu_pkg::DATA_W-1:0] req_sample,
   input  logic                                req_sample_null,
   input  logic                                req_new_group,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [emawu_pkg::DATA_W-1:0] rsp_average,
   output logic                                rsp_result_null,
   input  logic                                csr_we,
   input  logic [emawu_pkg::PERIOD_W-1:0]      csr_wdata
);
   import emawu_pkg::*;

   cmd_type    cmd;
   status_type status;

   emawu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   emawu_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_sample),
      .req_sample_null (req_sample_null),
      .req_new_group   (req_new_group),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_average     (rsp_average),
      .rsp_result_null (rsp_result_null)
   );

endmodule
